/* hdl/ptob_pkg.sv */
// Package with the command, status and sequencer types of the order book.
`default_nettype none
package ptob_pkg;

  localparam int unsigned IdW     = 32;
  localparam int unsigned TimeW   = 48;
  localparam int unsigned TraderW = 16;
  localparam int unsigned PortPriceW = 32;
  localparam int unsigned DataW   = 136;

  typedef enum logic [1:0] {
    CMD_INSERT     = 2'd0,
    CMD_REMOVE     = 2'd1,
    CMD_BEST_BID   = 2'd2,
    CMD_BEST_OFFER = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_DUP_ID    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_DONE
  } seq_e;

endpackage
`default_nettype wire

/* hdl/ptob_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module ptob_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

/* hdl/ptob_cmp.sv */
// Shared compare unit: id match and price-time-id ranking of one slot against the best so far.
`default_nettype none
module ptob_cmp
  import ptob_pkg::*;
#(
  parameter int unsigned PW = 32
) (
  input  wire logic [IdW-1:0]   key_id_i,
  input  wire logic             side_i,
  input  wire logic [IdW-1:0]   cand_id_i,
  input  wire logic [PW-1:0]    cand_price_i,
  input  wire logic [TimeW-1:0] cand_time_i,
  input  wire logic [IdW-1:0]   best_id_i,
  input  wire logic [PW-1:0]    best_price_i,
  input  wire logic [TimeW-1:0] best_time_i,
  output      logic             id_eq_o,
  output      logic             ahead_o
);

  assign id_eq_o = (cand_id_i == key_id_i);

  // Bids rank higher prices first, offers lower; then earlier time, then lower id.
  always_comb begin
    if (cand_price_i != best_price_i) begin
      ahead_o = side_i ? (cand_price_i < best_price_i) : (cand_price_i > best_price_i);
    end else if (cand_time_i != best_time_i) begin
      ahead_o = cand_time_i < best_time_i;
    end else begin
      ahead_o = cand_id_i < best_id_i;
    end
  end

endmodule
`default_nettype wire

/* hdl/price_time_order_book.sv */
// Top level of the price-time priority order book with its scan sequencer.
//
// Commands enter on the slave stream: tuser carries the command code, tdata the
// order fields. Each command produces exactly one result item on the master stream,
// with the status in tuser and the returned order in tdata.
// Every command walks the whole slot memory, one slot per cycle through the
// memory's single registered read port and the shared compare unit. The result
// is loaded into the output register once the scan is done, and a new command is
// not accepted while an earlier one is still scanning.
// The next command can be accepted as soon as that result is loaded, even if it
// has not been taken yet.
// If the receiver stalls, the output register holds the result; a following
// command then completes its scan and waits until the output register is free.
// After reset the block runs a clearing pass that marks all slots free; tready
// stays low during that pass.
// Prices are stored with min(PRICE_BITS, 32) bits.
`default_nettype none
module price_time_order_book
  import ptob_pkg::*;
#(
  parameter int unsigned BOOK_DEPTH = 64,
  parameter int unsigned PRICE_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid_i,
  output      logic             s_axis_tready_o,
  // order_id[31:0], side[32], price[64:33], creation_time[112:65],
  // trader_id[128:113], zero fill above
  input  wire logic [DataW-1:0] s_axis_tdata_i,
  // cmd[1:0]
  input  wire logic [1:0]       s_axis_tuser_i,
  output      logic             m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  // out_order_id[31:0], out_side[32], out_price[64:33], out_creation_time[112:65],
  // out_trader_id[128:113], zero fill above
  output      logic [DataW-1:0] m_axis_tdata_o,
  // status[1:0]
  output      logic [1:0]       m_axis_tuser_o
);

  localparam int unsigned AW   = $clog2(BOOK_DEPTH);
  localparam int unsigned SW   = (PRICE_BITS < PortPriceW) ? PRICE_BITS : PortPriceW;
  localparam int unsigned OffId     = 1;
  localparam int unsigned OffSide   = OffId + IdW;
  localparam int unsigned OffPrice  = OffSide + 1;
  localparam int unsigned OffTime   = OffPrice + SW;
  localparam int unsigned OffTrader = OffTime + TimeW;
  localparam int unsigned RecW      = OffTrader + TraderW;
  localparam logic [AW-1:0] LastSlot = AW'(BOOK_DEPTH - 1);

  seq_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;

  // Command latched at acceptance.
  cmd_e               cmd_q, cmd_d;
  logic [IdW-1:0]     key_id_q, key_id_d;
  logic               in_side_q, in_side_d;
  logic [SW-1:0]      in_price_q, in_price_d;
  logic [TimeW-1:0]   in_time_q, in_time_d;
  logic [TraderW-1:0] in_trader_q, in_trader_d;

  // Scan results.
  logic               hit_q, hit_d;
  logic               dup_q, dup_d;
  logic               free_ok_q, free_ok_d;
  logic [AW-1:0]      free_q, free_d;
  logic [AW-1:0]      found_q, found_d;
  logic [IdW-1:0]     best_id_q, best_id_d;
  logic               best_side_q, best_side_d;
  logic [SW-1:0]      best_price_q, best_price_d;
  logic [TimeW-1:0]   best_time_q, best_time_d;
  logic [TraderW-1:0] best_trader_q, best_trader_d;

  // Output register.
  logic               out_valid_q, out_valid_d;
  logic [DataW-1:0]   out_data_q, out_data_d;
  status_e            out_status_q, out_status_d;

  // Memory ports.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [RecW-1:0]    ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [RecW-1:0]    ram_rdata;

  logic               rd_valid;
  logic [IdW-1:0]     rd_id;
  logic               rd_side;
  logic [SW-1:0]      rd_price;
  logic [TimeW-1:0]   rd_time;
  logic [TraderW-1:0] rd_trader;
  logic               id_eq;
  logic               ahead;
  logic               query_side;
  logic               s_accept;
  logic               out_free;

  assign rd_valid  = ram_rdata[0];
  assign rd_id     = ram_rdata[OffId +: IdW];
  assign rd_side   = ram_rdata[OffSide];
  assign rd_price  = ram_rdata[OffPrice +: SW];
  assign rd_time   = ram_rdata[OffTime +: TimeW];
  assign rd_trader = ram_rdata[OffTrader +: TraderW];

  assign query_side = (cmd_q == CMD_BEST_OFFER);
  assign s_axis_tready_o = (state_q == SEQ_IDLE);
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  // The first slot is read in the accept cycle; each later slot in the scan cycle before its compare.
  assign ram_raddr = (state_q == SEQ_SCAN) ? idx_q + AW'(1) : '0;

  ptob_ram #(
    .WIDTH (RecW),
    .DEPTH (BOOK_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ptob_cmp #(
    .PW (SW)
  ) u_cmp (
    .key_id_i     (key_id_q),
    .side_i       (query_side),
    .cand_id_i    (rd_id),
    .cand_price_i (rd_price),
    .cand_time_i  (rd_time),
    .best_id_i    (best_id_q),
    .best_price_i (best_price_q),
    .best_time_i  (best_time_q),
    .id_eq_o      (id_eq),
    .ahead_o      (ahead)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_CLEAR;
      idx_q       <= '0;
      cmd_q       <= CMD_INSERT;
      hit_q       <= 1'b0;
      dup_q       <= 1'b0;
      free_ok_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cmd_q       <= cmd_d;
      hit_q       <= hit_d;
      dup_q       <= dup_d;
      free_ok_q   <= free_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_id_q      <= key_id_d;
    in_side_q     <= in_side_d;
    in_price_q    <= in_price_d;
    in_time_q     <= in_time_d;
    in_trader_q   <= in_trader_d;
    free_q        <= free_d;
    found_q       <= found_d;
    best_id_q     <= best_id_d;
    best_side_q   <= best_side_d;
    best_price_q  <= best_price_d;
    best_time_q   <= best_time_d;
    best_trader_q <= best_trader_d;
    out_data_q    <= out_data_d;
    out_status_q  <= out_status_d;
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_d         = cmd_q;
    key_id_d      = key_id_q;
    in_side_d     = in_side_q;
    in_price_d    = in_price_q;
    in_time_d     = in_time_q;
    in_trader_d   = in_trader_q;
    hit_d         = hit_q;
    dup_d         = dup_q;
    free_ok_d     = free_ok_q;
    free_d        = free_q;
    found_d       = found_q;
    best_id_d     = best_id_q;
    best_side_d   = best_side_q;
    best_price_d  = best_price_q;
    best_time_d   = best_time_q;
    best_trader_d = best_trader_q;
    out_valid_d   = out_valid_q && !m_axis_tready_i;
    out_data_d    = out_data_q;
    out_status_d  = out_status_q;
    ram_we        = 1'b0;
    ram_waddr     = idx_q;
    ram_wdata     = '0;

    unique case (state_q)
      SEQ_CLEAR: begin
        ram_we = 1'b1;
        idx_d  = idx_q + AW'(1);
        if (idx_q == LastSlot) begin
          idx_d   = '0;
          state_d = SEQ_IDLE;
        end
      end

      SEQ_IDLE: begin
        if (s_accept) begin
          cmd_d       = cmd_e'(s_axis_tuser_i);
          key_id_d    = s_axis_tdata_i[0 +: IdW];
          in_side_d   = s_axis_tdata_i[IdW];
          in_price_d  = s_axis_tdata_i[IdW+1 +: SW];
          in_time_d   = s_axis_tdata_i[IdW+1+PortPriceW +: TimeW];
          in_trader_d = s_axis_tdata_i[IdW+1+PortPriceW+TimeW +: TraderW];
          hit_d       = 1'b0;
          dup_d       = 1'b0;
          free_ok_d   = 1'b0;
          idx_d       = '0;
          state_d     = SEQ_SCAN;
        end
      end

      SEQ_SCAN: begin
        unique case (cmd_q)
          CMD_INSERT: begin
            if (rd_valid && id_eq) begin
              dup_d = 1'b1;
            end
            if (!rd_valid && !free_ok_q) begin
              free_ok_d = 1'b1;
              free_d    = idx_q;
            end
          end
          CMD_REMOVE: begin
            if (rd_valid && id_eq && !hit_q) begin
              hit_d         = 1'b1;
              found_d       = idx_q;
              best_id_d     = rd_id;
              best_side_d   = rd_side;
              best_price_d  = rd_price;
              best_time_d   = rd_time;
              best_trader_d = rd_trader;
            end
          end
          CMD_BEST_BID, CMD_BEST_OFFER: begin
            if (rd_valid && (rd_side == query_side) && (!hit_q || ahead)) begin
              hit_d         = 1'b1;
              best_id_d     = rd_id;
              best_side_d   = rd_side;
              best_price_d  = rd_price;
              best_time_d   = rd_time;
              best_trader_d = rd_trader;
            end
          end
          default: ;
        endcase
        idx_d = idx_q + AW'(1);
        if (idx_q == LastSlot) begin
          state_d = SEQ_DONE;
        end
      end

      SEQ_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = '0;
          out_status_d = ST_OK;
          state_d      = SEQ_IDLE;
          if (cmd_q == CMD_INSERT) begin
            if (dup_q) begin
              out_status_d = ST_DUP_ID;
            end else if (!free_ok_q) begin
              out_status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = free_q;
              ram_wdata = {in_trader_q, in_time_q, in_price_q, in_side_q, key_id_q, 1'b1};
            end
          end else if (!hit_q) begin
            out_status_d = ST_NOT_FOUND;
          end else begin
            out_data_d = {{(DataW-IdW-1-PortPriceW-TimeW-TraderW){1'b0}}, best_trader_q,
                          best_time_q, PortPriceW'(best_price_q), best_side_q, best_id_q};
            if (cmd_q == CMD_REMOVE) begin
              // Clearing the word frees the slot.
              ram_we    = 1'b1;
              ram_waddr = found_q;
            end
          end
        end
      end

      default: state_d = SEQ_CLEAR;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_CLEAR) |-> !s_axis_tready_o)
    else $error("command accepted during the clearing pass");

  a_done_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_DONE && out_free) |=> m_axis_tvalid_o)
    else $error("finished command produced no result");

  a_write_only_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == SEQ_CLEAR || state_q == SEQ_DONE))
    else $error("slot memory written during a scan");

  a_dup_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_DONE && dup_q) |-> (cmd_q == CMD_INSERT))
    else $error("duplicate flag set on a non-insert command");

endmodule
`default_nettype wire

/* verif/price_time_order_book_tb.sv */
// Self-checking testbench for the price-time priority order book.
`timescale 1ns / 100ps

module price_time_order_book_tb;
  import ptob_pkg::*;

  localparam int unsigned BookDepth = 64;
  localparam int unsigned PriceBits = 32;
  localparam int unsigned ScanCycles = BookDepth + 2;
  // Mean length of one receiver stall in cycles, long and short ones together.
  localparam real RecvMeanStall = 8.5;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [47:0] ctime;
    logic [15:0] trader;
  } order_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] id;
    logic        side;
    logic [31:0] price;
    logic [47:0] ctime;
    logic [15:0] trader;
  } book_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic [1:0]       s_axis_tuser = CMD_INSERT;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  // Shadow copy of the resting orders, updated as each item is accepted.
  logic        book_live   [BookDepth];
  logic [31:0] book_id     [BookDepth];
  logic        book_side   [BookDepth];
  logic [31:0] book_price  [BookDepth];
  logic [47:0] book_time   [BookDepth];
  logic [15:0] book_trader [BookDepth];

  book_result_t expected_q[$];
  int fail_count = 0;
  int send_gap_pct = 0;
  int stall_start_ppm = 0;
  int stall_left = 0;

  price_time_order_book #(
    .BOOK_DEPTH(BookDepth),
    .PRICE_BITS(PriceBits)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // True when slot a ranks ahead of slot b among the orders of one side.
  function automatic bit outranks(int a, int b, logic offer_side);
    if (book_price[a] != book_price[b]) begin
      return offer_side ? (book_price[a] < book_price[b]) : (book_price[a] > book_price[b]);
    end
    if (book_time[a] != book_time[b]) begin
      return book_time[a] < book_time[b];
    end
    return book_id[a] < book_id[b];
  endfunction

  function automatic book_result_t book_apply(order_cmd_t c);
    book_result_t r;
    int hit;
    int free_idx;
    logic want_side;
    r = '0;
    r.status = ST_OK;
    hit = -1;
    free_idx = -1;
    case (c.cmd)
      CMD_INSERT: begin
        for (int i = 0; i < BookDepth; i++) begin
          if (book_live[i]) begin
            if (book_id[i] == c.id) hit = i;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (hit >= 0) begin
          r.status = ST_DUP_ID;
        end else if (free_idx < 0) begin
          r.status = ST_FULL;
        end else begin
          book_live[free_idx]   = 1'b1;
          book_id[free_idx]     = c.id;
          book_side[free_idx]   = c.side;
          book_price[free_idx]  = c.price;
          book_time[free_idx]   = c.ctime;
          book_trader[free_idx] = c.trader;
        end
        return r;
      end
      CMD_REMOVE: begin
        for (int i = 0; i < BookDepth; i++) begin
          if (hit < 0 && book_live[i] && book_id[i] == c.id) hit = i;
        end
      end
      default: begin
        want_side = (c.cmd == CMD_BEST_OFFER);
        for (int i = 0; i < BookDepth; i++) begin
          if (book_live[i] && book_side[i] == want_side) begin
            if (hit < 0 || outranks(i, hit, want_side)) hit = i;
          end
        end
      end
    endcase
    if (hit < 0) begin
      r.status = ST_NOT_FOUND;
    end else begin
      r.id     = book_id[hit];
      r.side   = book_side[hit];
      r.price  = book_price[hit];
      r.ctime  = book_time[hit];
      r.trader = book_trader[hit];
      if (c.cmd == CMD_REMOVE) book_live[hit] = 1'b0;
    end
    return r;
  endfunction

  function automatic int live_count();
    int n;
    n = 0;
    for (int i = 0; i < BookDepth; i++) n += book_live[i];
    return n;
  endfunction

  // Id of a randomly chosen resting order; the book must not be empty.
  function automatic logic [31:0] resting_id();
    int k;
    k = $urandom_range(0, live_count() - 1);
    for (int i = 0; i < BookDepth; i++) begin
      if (book_live[i]) begin
        if (k == 0) return book_id[i];
        k--;
      end
    end
    return '0;
  endfunction

  function automatic order_cmd_t make_cmd(cmd_e cmd, logic [31:0] id, logic side,
                                          logic [31:0] price, logic [47:0] ctime,
                                          logic [15:0] trader);
    order_cmd_t c;
    c.cmd = cmd;
    c.id = id;
    c.side = side;
    c.price = price;
    c.ctime = ctime;
    c.trader = trader;
    return c;
  endfunction

  // Small ranges give many price and time ties; the rest reach every bit.
  function automatic order_cmd_t random_fields(cmd_e cmd);
    order_cmd_t c;
    c.cmd = cmd;
    case ($urandom_range(0, 9))
      0:       c.id = $urandom;
      1:       c.id = 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: c.id = $urandom_range(0, 300);
    endcase
    c.side = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       c.price = '0;
      1:       c.price = '1;
      2, 3:    c.price = $urandom;
      default: c.price = 1000 + $urandom_range(0, 15);
    endcase
    case ($urandom_range(0, 9))
      0:       c.ctime = '0;
      1:       c.ctime = '1;
      2, 3:    c.ctime = {16'($urandom_range(0, 65535)), 32'($urandom)};
      default: c.ctime = 48'($urandom_range(0, 7));
    endcase
    c.trader = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  task automatic send_cmd(order_cmd_t c);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= c.cmd;
    s_axis_tdata  <= {7'b0, c.trader, c.ctime, c.price, c.side, c.id};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(book_apply(c));
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 140);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: stalls start at a rate chosen so that the requested share of cycles
  // is stalled; one stall in sixteen is long enough that a finished scan has to
  // wait for the output register.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_start_ppm > 0 && $urandom_range(0, 999_999) < stall_start_ppm) begin
      stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(70, 140) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : result_check
    book_result_t got;
    book_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tuser);
      got.id     = m_axis_tdata[31:0];
      got.side   = m_axis_tdata[32];
      got.price  = m_axis_tdata[64:33];
      got.ctime  = m_axis_tdata[112:65];
      got.trader = m_axis_tdata[128:113];
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result item: status=%0d id=%h", got.status, got.id);
        end
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch at %0t: expected status=%0d id=%h side=%b price=%h time=%h trader=%h",
                     $realtime, want.status, want.id, want.side, want.price, want.ctime,
                     want.trader);
            $display("              got status=%0d id=%h side=%b price=%h time=%h trader=%h",
                     got.status, got.id, got.side, got.price, got.ctime, got.trader);
          end
        end
      end
    end
  end

  task automatic test_directed();
    send_cmd(make_cmd(CMD_BEST_BID, 32'd1, 1'b1, '1, '1, '1));
    send_cmd(make_cmd(CMD_BEST_OFFER, '1, 1'b0, '0, '0, '0));
    send_cmd(make_cmd(CMD_REMOVE, 32'd5, 1'b1, 32'h1234_5678, '1, 16'hBEEF));
    send_cmd(make_cmd(CMD_INSERT, '1, 1'b1, '1, '1, '1));
    send_cmd(make_cmd(CMD_INSERT, '0, 1'b0, '0, '0, '0));
    send_cmd(make_cmd(CMD_INSERT, '0, 1'b1, 32'd7, 48'd7, 16'd7));
    send_cmd(make_cmd(CMD_BEST_BID, '0, 1'b0, '0, '0, '0));
    send_cmd(make_cmd(CMD_BEST_OFFER, '0, 1'b0, '0, '0, '0));
    // Equal prices on the bid side: earliest time first, then lowest id.
    send_cmd(make_cmd(CMD_INSERT, 32'd10, 1'b0, 32'd500, 48'd20, 16'd1));
    send_cmd(make_cmd(CMD_INSERT, 32'd11, 1'b0, 32'd500, 48'd10, 16'd2));
    send_cmd(make_cmd(CMD_INSERT, 32'd9, 1'b0, 32'd500, 48'd10, 16'd3));
    send_cmd(make_cmd(CMD_INSERT, 32'd12, 1'b0, 32'd499, 48'd1, 16'd4));
    send_cmd(make_cmd(CMD_BEST_BID, 32'd77, 1'b1, '1, '1, '1));
    send_cmd(make_cmd(CMD_INSERT, 32'd20, 1'b1, 32'd700, 48'd5, 16'd5));
    send_cmd(make_cmd(CMD_INSERT, 32'd21, 1'b1, 32'd700, 48'd3, 16'd6));
    send_cmd(make_cmd(CMD_INSERT, 32'd22, 1'b1, 32'd701, 48'd0, 16'd7));
    send_cmd(make_cmd(CMD_BEST_OFFER, '0, 1'b0, '0, '0, '0));
    send_cmd(make_cmd(CMD_REMOVE, 32'd9, 1'b1, '1, '1, '1));
    send_cmd(make_cmd(CMD_BEST_BID, '0, 1'b0, '0, '0, '0));
    send_cmd(make_cmd(CMD_REMOVE, 32'd9, 1'b0, '0, '0, '0));
    send_cmd(make_cmd(CMD_INSERT, 32'd9, 1'b1, 32'd650, 48'd2, 16'd8));
    send_cmd(make_cmd(CMD_REMOVE, '1, 1'b0, '0, '0, '0));
    send_cmd(make_cmd(CMD_BEST_OFFER, 32'hA5A5_A5A5, 1'b0, 32'h5A5A_5A5A, '1, 16'h1234));
  endtask

  // Fill every slot, overflow it, try a duplicate while full, then drain.
  task automatic test_table_full();
    order_cmd_t c;
    int seq_id;
    seq_id = 0;
    while (live_count() < BookDepth + 0) begin
      c = random_fields(CMD_INSERT);
      c.id = 32'h8000_0000 + seq_id;
      seq_id++;
      send_cmd(c);
    end
    repeat (2) begin
      c = random_fields(CMD_INSERT);
      c.id = 32'h4000_0000 + $urandom_range(0, 1000);
      send_cmd(c);
    end
    c = random_fields(CMD_INSERT);
    c.id = resting_id();
    send_cmd(c);
    send_cmd(random_fields(CMD_BEST_BID));
    send_cmd(random_fields(CMD_BEST_OFFER));
    while (live_count() > 0) begin
      c = random_fields(CMD_REMOVE);
      c.id = resting_id();
      send_cmd(c);
      if ($urandom_range(0, 3) == 0) send_cmd(random_fields(CMD_BEST_BID));
      if ($urandom_range(0, 3) == 0) send_cmd(random_fields(CMD_BEST_OFFER));
    end
  endtask

  task automatic test_random(int gap_pct, int stall_pct, int count);
    order_cmd_t c;
    int live;
    int roll;
    int insert_pct;
    real frac;
    send_gap_pct = gap_pct;
    frac = stall_pct / 100.0;
    stall_start_ppm = int'(1.0e6 * frac / (RecvMeanStall * (1.0 - frac) + frac));
    repeat (count) begin
      live = live_count();
      roll = $urandom_range(0, 99);
      insert_pct = (live < 16) ? 60 : (live > 56) ? 35 : 45;
      if (roll < insert_pct) begin
        c = random_fields(CMD_INSERT);
        if (live > 0 && $urandom_range(0, 9) == 0) c.id = resting_id();
      end else if (roll < insert_pct + 30) begin
        c = random_fields(CMD_REMOVE);
        if (live > 0 && $urandom_range(0, 4) != 0) c.id = resting_id();
      end else begin
        c = random_fields($urandom_range(0, 1) ? CMD_BEST_BID : CMD_BEST_OFFER);
      end
      send_cmd(c);
    end
  endtask

  initial begin
    for (int i = 0; i < BookDepth; i++) book_live[i] = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_table_full();
    test_random(0, 0, 250);
    test_random(46, 0, 250);
    test_random(0, 46, 250);
    test_random(14, 14, 250);
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (4 * ScanCycles) @(posedge clk_i);
    fail_count += expected_q.size();
    if (fail_count == 0) begin
      $display("price_time_order_book test passed");
    end else begin
      $display("price_time_order_book test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("price_time_order_book test failed");
    $finish;
  end

endmodule

/* sim.f */
hdl/ptob_pkg.sv
hdl/ptob_ram.sv
hdl/ptob_cmp.sv
hdl/price_time_order_book.sv
verif/price_time_order_book_tb.sv
